### hw/rtl/tcw_pkg.sv
// Shared constants for the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Field widths of the transfer payloads.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;

  // Action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Control bytes.
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACK    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam int unsigned TAB_SPACES = 4;
  localparam int unsigned TAB_CNT_W  = $clog2(TAB_SPACES);

endpackage

`default_nettype wire

### hw/rtl/tcw_ram.sv
// Screen store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram
  import tcw_pkg::*;
#(
  parameter int unsigned AW    = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [CHAR_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/text_console_char_writer.sv
// Text console writer: cursor control, scrolling ring of rows, and cell reads.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, action_i, char_code_i,  | into block
//           | read_row_i, read_col_i                          |
//   out     | out_valid_o, out_ready_i, read_char_o,          | out of block
//           | cursor_row_o, cursor_col_o                      |
//
// A pending wrap is resolved before the next write; each scroll blanks the recycled row
// one cell per cycle. After reset the store is cleared to spaces; in_ready_o stays low then.
// A finished result waits in the output register while the next item is taken in; the
// sequencer holds its result only when that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLS = 88,
  parameter int unsigned ROWS = 21
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              action_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  read_row_i,
  input  wire logic [COL_W-1:0]  read_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [CHAR_W-1:0] read_char_o,
  output logic      [ROW_W-1:0]  cursor_row_o,
  output logic      [COL_W-1:0]  cursor_col_o
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned CCW   = $clog2(COLS + 1);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = ROWS * (2 ** CW);

  localparam logic [RW:0]    ROWS_EXT = (RW + 1)'(ROWS);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0]  COL_LAST = CW'(COLS - 1);
  localparam logic [CCW-1:0] COL_END  = CCW'(COLS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PUT    = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CCW-1:0]       col_q, col_d;
  logic [RW-1:0]        top_q, top_d;
  logic [RW-1:0]        clr_row_q, clr_row_d;
  logic [CW-1:0]        clr_col_q, clr_col_d;
  logic                 ret_put_q, ret_put_d;
  logic [TAB_CNT_W-1:0] cnt_q, cnt_d;
  logic [CHAR_W-1:0]    put_char_q, put_char_d;
  logic [CHAR_W-1:0]    res_char_q, res_char_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    out_char_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [COL_W-1:0]     out_col_q;
  logic                 out_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  logic [RW:0]    cur_sum;
  logic [RW-1:0]  cur_phys;
  logic [RW:0]    rd_sum;
  logic [RW-1:0]  rd_phys;
  logic           rd_in_range;
  logic [CCW-1:0] col_dec;

  // Logical rows map onto physical rows through the top-row offset, a ring of ROWS.
  assign cur_sum  = {1'b0, top_q} + {1'b0, row_q};
  assign cur_phys = (cur_sum >= ROWS_EXT) ? RW'(cur_sum - ROWS_EXT) : cur_sum[RW-1:0];
  assign rd_sum   = {1'b0, top_q} + {1'b0, read_row_i[RW-1:0]};
  assign rd_phys  = (rd_sum >= ROWS_EXT) ? RW'(rd_sum - ROWS_EXT) : rd_sum[RW-1:0];
  assign rd_in_range = ({1'b0, read_row_i} < (ROW_W + 1)'(ROWS)) &&
                       ({1'b0, read_col_i} < (COL_W + 1)'(COLS));
  assign col_dec   = col_q - CCW'(1);
  assign mem_raddr = {rd_phys, read_col_i[CW-1:0]};

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    top_d      = top_q;
    clr_row_d  = clr_row_q;
    clr_col_d  = clr_col_q;
    ret_put_d  = ret_put_q;
    cnt_d      = cnt_q;
    put_char_d = put_char_q;
    res_char_d = res_char_q;
    mem_we     = 1'b0;
    mem_waddr  = {clr_row_q, clr_col_q};
    mem_wdata  = CH_SPACE;
    mem_re     = 1'b0;

    case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        if (clr_col_q == COL_LAST) begin
          clr_col_d = '0;
          if (clr_row_q == ROW_LAST) begin
            state_d = S_IDLE;
          end else begin
            clr_row_d = clr_row_q + RW'(1);
          end
        end else begin
          clr_col_d = clr_col_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_char_d = '0;
          if (action_i == ACT_READ) begin
            if (rd_in_range) begin
              mem_re  = 1'b1;
              state_d = S_RDWAIT;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            case (char_code_i)
              CH_NEWLINE: begin
                col_d = '0;
                if (row_q == ROW_LAST) begin
                  clr_row_d = top_q;
                  clr_col_d = '0;
                  ret_put_d = 1'b0;
                  state_d   = S_SCROLL;
                end else begin
                  row_d   = row_q + RW'(1);
                  state_d = S_DONE;
                end
              end
              CH_RETURN: begin
                col_d   = '0;
                state_d = S_DONE;
              end
              CH_BACK: begin
                if (col_q != '0) begin
                  col_d     = col_dec;
                  mem_we    = 1'b1;
                  mem_waddr = {cur_phys, col_dec[CW-1:0]};
                end
                state_d = S_DONE;
              end
              CH_TAB: begin
                put_char_d = CH_SPACE;
                cnt_d      = TAB_CNT_W'(TAB_SPACES - 1);
                state_d    = S_PUT;
              end
              default: begin
                put_char_d = char_code_i;
                cnt_d      = '0;
                state_d    = S_PUT;
              end
            endcase
          end
        end
      end
      S_PUT: begin
        if (col_q == COL_END) begin
          // Deferred wrap: move to the next row first, scrolling on the bottom row, then write.
          col_d = '0;
          if (row_q == ROW_LAST) begin
            clr_row_d = top_q;
            clr_col_d = '0;
            ret_put_d = 1'b1;
            state_d   = S_SCROLL;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {cur_phys, col_q[CW-1:0]};
          mem_wdata = put_char_q;
          col_d     = col_q + CCW'(1);
          if (cnt_q == '0) begin
            state_d = S_DONE;
          end else begin
            cnt_d = cnt_q - TAB_CNT_W'(1);
          end
        end
      end
      S_SCROLL: begin
        // The old top row is blanked and becomes the new bottom row.
        mem_we = 1'b1;
        if (clr_col_q == COL_LAST) begin
          clr_col_d = '0;
          top_d     = (top_q == ROW_LAST) ? '0 : top_q + RW'(1);
          state_d   = ret_put_q ? S_PUT : S_DONE;
        end else begin
          clr_col_d = clr_col_q + CW'(1);
        end
      end
      S_RDWAIT: begin
        res_char_d = mem_rdata;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      clr_row_q   <= '0;
      clr_col_q   <= '0;
      ret_put_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      clr_row_q   <= clr_row_d;
      clr_col_q   <= clr_col_d;
      ret_put_q   <= ret_put_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    put_char_q <= put_char_d;
    res_char_q <= res_char_d;
    if (out_load) begin
      out_char_q <= res_char_q;
      out_row_q  <= ROW_W'(row_q);
      out_col_q  <= COL_W'(col_q);
    end
  end

  tcw_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_char_o  = out_char_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_END)
    else $error("cursor column beyond the pending-wrap position");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < ROWS_EXT) && ({1'b0, top_q} < ROWS_EXT))
    else $error("cursor row or top-row offset out of range");

  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL) |-> (row_q == ROW_LAST))
    else $error("scroll running while the cursor is not on the bottom row");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted transfer produced no work");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result loaded without raising out_valid_o");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import tcw_pkg::*;

  localparam int unsigned COLS  = 88;
  localparam int unsigned ROWS  = 21;
  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned RANDOM_ITEMS = 1850;

  typedef struct packed {
    logic [CHAR_W-1:0] rd_char;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_result_t;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_HOLD
  } ready_mode_e;

  // Tracks the screen, the ring offset and the cursor, and holds the results
  // still to come from the block.
  class console_scoreboard;
    logic [CHAR_W-1:0] cells [CELLS];
    int unsigned       top_row;
    int unsigned       cur_row;
    int unsigned       cur_col;
    console_result_t   pending_q[$];
    int unsigned       mismatches;
    int unsigned       unexpected;

    function new();
      foreach (cells[i]) cells[i] = CH_SPACE;
      top_row    = 0;
      cur_row    = 0;
      cur_col    = 0;
      mismatches = 0;
      unexpected = 0;
    endfunction

    function int unsigned cell_index(int unsigned row, int unsigned col);
      return ((top_row + row) % ROWS) * COLS + col;
    endfunction

    // The old top physical row is recycled as the new blank bottom row.
    function void scroll_up();
      int unsigned old_top;
      old_top = top_row;
      top_row = (top_row + 1) % ROWS;
      for (int unsigned c = 0; c < COLS; c++) cells[old_top * COLS + c] = CH_SPACE;
    endfunction

    function void next_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
        scroll_up();
        cur_row = ROWS - 1;
      end
    endfunction

    function void put_plain(logic [CHAR_W-1:0] ch);
      if (cur_col >= COLS) next_line();
      cells[cell_index(cur_row, cur_col)] = ch;
      cur_col++;
    endfunction

    function void take_item(logic act, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] row,
                            logic [COL_W-1:0] col);
      console_result_t res;
      res.rd_char = '0;
      if (act == ACT_WRITE) begin
        case (ch)
          CH_NEWLINE: next_line();
          CH_RETURN:  cur_col = 0;
          CH_BACK: begin
            if (cur_col > 0) begin
              cur_col--;
              cells[cell_index(cur_row, cur_col)] = CH_SPACE;
            end
          end
          CH_TAB: begin
            for (int unsigned i = 0; i < TAB_SPACES; i++) put_plain(CH_SPACE);
          end
          default: put_plain(ch);
        endcase
      end else if (row < ROWS && col < COLS) begin
        res.rd_char = cells[cell_index(row, col)];
      end
      res.row = ROW_W'(cur_row);
      res.col = COL_W'(cur_col);
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [CHAR_W-1:0] rd_char, logic [ROW_W-1:0] row,
                               logic [COL_W-1:0] col);
      console_result_t want;
      if (pending_q.size() == 0) begin
        unexpected++;
        if (unexpected <= 10)
          $display("unexpected result: char %02h row %0d col %0d", rd_char, row, col);
        return;
      end
      want = pending_q.pop_front();
      if (want.rd_char !== rd_char || want.row !== row || want.col !== col) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected char %02h row %0d col %0d, got char %02h row %0d col %0d",
                   $time, want.rd_char, want.row, want.col, rd_char, row, col);
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              action_i    = ACT_WRITE;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [ROW_W-1:0]  read_row_i  = '0;
  logic [COL_W-1:0]  read_col_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CHAR_W-1:0] read_char_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [COL_W-1:0]  cursor_col_o;

  console_scoreboard board = new();

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  ready_mode_e ready_mode = RDY_ALWAYS;
  int unsigned ready_left = 0;

  text_console_char_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_char_o (read_char_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: checks each output transfer and stalls in stretches of its own.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(read_char_o, cursor_row_o, cursor_col_o);
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      ready_left = $urandom_range(5, 60);
    end
    ready_left--;
    case (ready_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_RANDOM: out_ready_i <= ($urandom_range(0, 2) != 0);
      default:    out_ready_i <= 1'b0;
    endcase
  end

  // Called at a rising edge; returns at the edge where the transfer happened.
  // Every lowering of valid is followed by an idle gap before the next item.
  task automatic send_item(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    char_code_i <= ch;
    read_row_i  <= row;
    read_col_i  <= col;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_item(act, ch, row, col);
    items_sent++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // The unused fields of an item carry random bits.
  task automatic send_write(input logic [CHAR_W-1:0] ch);
    send_item(ACT_WRITE, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), row, col);
  endtask

  // In-range read, often on the cursor row where the recent writes landed.
  task automatic send_screen_read();
    logic [ROW_W-1:0] row;
    row = ($urandom_range(0, 2) == 0) ? ROW_W'(board.cur_row) : ROW_W'($urandom_range(0, ROWS - 1));
    send_read(row, COL_W'($urandom_range(0, COLS - 1)));
  endtask

  task automatic send_line_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) send_screen_read();
    else if (pick < 16) send_write(CH_BACK);
    else if (pick < 19) send_write(CH_TAB);
    else if (pick < 25) send_write(CHAR_W'($urandom_range(0, 255)));
    else send_write(CHAR_W'($urandom_range(33, 126)));
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned pick;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: backspace at column 0, reads out of range, byte extremes,
    // a full row of tabs, then a backspace with the wrap pending and a tab that wraps.
    send_write(CH_BACK);
    send_read(ROW_W'(31), COL_W'(127));
    send_read(ROW_W'(ROWS), COL_W'(0));
    send_read(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
    send_write(8'h00);
    send_write(8'hFF);
    send_read(ROW_W'(0), COL_W'(1));
    send_write(CH_RETURN);
    repeat (COLS / TAB_SPACES) send_write(CH_TAB);
    send_write(CH_BACK);
    send_write(CH_TAB);
    send_write(CH_NEWLINE);

    while (items_sent < RANDOM_ITEMS + 25) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // A text line, sometimes long enough to wrap.
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 100) : $urandom_range(1, 30);
        repeat (len) send_line_byte();
        pick = $urandom_range(0, 99);
        if (pick < 70) send_write(CH_NEWLINE);
        else if (pick < 85) send_write(CH_RETURN);
      end else if (kind < 62) begin
        // Fill the row until the wrap is pending, then poke the pending state.
        while (board.cur_col < COLS) begin
          if ($urandom_range(0, 9) == 0) send_screen_read();
          else send_write(CHAR_W'($urandom_range(33, 126)));
        end
        case ($urandom_range(0, 5))
          0: send_write(CH_BACK);
          1: send_write(CH_NEWLINE);
          2: send_write(CH_RETURN);
          3: send_write(CH_TAB);
          4: send_write(CHAR_W'($urandom_range(0, 255)));
          default: send_screen_read();
        endcase
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 4) == 0)
            send_read(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
          else
            send_screen_read();
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                  ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
      end
    end

    if (burst_left != 0) begin
      burst_left = 0;
      in_valid_i <= 1'b0;
    end

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (board.mismatches == 0 && board.unexpected == 0 && board.pending_q.size() == 0) begin
      $display("text_console_char_writer regression: pass");
    end else begin
      $display("text_console_char_writer regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("text_console_char_writer regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_char_writer.sv
sim/tb.sv
